// ===== rtl/core/esabg_pkg.sv =====
// ----------------------------------------------------------------------------
// esabg_pkg
// Shared types and constants of the environment sample averager with battery
// gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package esabg_pkg;

  localparam int WINDOW_LEN_DEF = 20;

  localparam int TEMP_C_W  = 15;
  localparam int TEMP_F_W  = 16;
  localparam int HUMID_W   = 14;
  localparam int BATT_W    = 10;
  localparam int PCT_W     = 7;

  localparam int TEMP9_W   = 19;
  localparam int MAG_W     = 18;
  localparam int RECIP_W   = 22;
  localparam int RECIP_SH  = 24;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] F_RECIP = 22'd3355444;
  localparam logic signed [TEMP_F_W-1:0] F_OFFSET = 16'sd3200;

  localparam int NUM_W     = 17;
  localparam logic [PCT_W-1:0] BATT_MAX = 7'd99;
  localparam logic [PCT_W-1:0] BATT_MIN = 7'd0;

  localparam int DVSR_W    = 10;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam logic [0:0] REG_FULL  = 1'b0;
  localparam logic [0:0] REG_EMPTY = 1'b1;
  localparam logic [BATT_W-1:0] FULL_RST  = 10'd700;
  localparam logic [BATT_W-1:0] EMPTY_RST = 10'd560;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_FCONV,
    ST_UPD,
    ST_AVG,
    ST_BGO,
    ST_BWAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  load;
    logic  mul;
    logic  fconv;
    logic  upd;
    logic  avg;
    logic  div_start;
    logic  cap_batt;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic batt_clamp;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/esabg_div.sv =====
// ----------------------------------------------------------------------------
// esabg_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module esabg_div
  import esabg_pkg::*;
#(
  parameter int DIV_W = 21
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [DVSR_W-1:0] divisor,
  output logic                   busy,
  output logic [DIV_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DVSR_W-1:0] dvsr;
  logic [DVSR_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic              fits;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign fits    = shifted >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr     <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esabg_ctrl.sv =====
// ----------------------------------------------------------------------------
// esabg_ctrl
// Sequencer that steps one sample word through conversion, ring update, the
// window averages and, unless the battery reading clamps, the battery
// division, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module esabg_ctrl
  import esabg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_FCONV;
      end
      ST_FCONV: begin
        cmd.fconv  = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_AVG;
      end
      ST_AVG: begin
        cmd.avg    = 1'b1;
        state_next = ST_BGO;
      end
      ST_BGO: begin
        if (status.batt_clamp) begin
          state_next = ST_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_BWAIT;
        end
      end
      ST_BWAIT: begin
        if (!status.div_busy) begin
          cmd.cap_batt = 1'b1;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/esabg_dp.sv =====
// ----------------------------------------------------------------------------
// esabg_dp
// Datapath: Fahrenheit conversion, sample rings with running sums, window
// averages by reciprocal multiplication, battery scaling with the divider and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module esabg_dp
  import esabg_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire cmd_t                       cmd,
  output status_t                         status,
  input  wire logic signed [TEMP_C_W-1:0] temp_centi_c,
  input  wire logic [HUMID_W-1:0]         humid_centi_pct,
  input  wire logic [BATT_W-1:0]          batt_raw,
  input  wire logic [BATT_W-1:0]          batt_full_level,
  input  wire logic [BATT_W-1:0]          batt_empty_level,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output logic signed [TEMP_F_W-1:0]      temp_centi_f,
  output logic [HUMID_W-1:0]              humid_now,
  output logic signed [TEMP_F_W-1:0]      temp_avg_centi_f,
  output logic [HUMID_W-1:0]              humid_avg,
  output logic [PCT_W-1:0]                batt_percent
);

  localparam int SLOT_W = $clog2(WINDOW_LEN);
  localparam int TSUM_W = TEMP_F_W + $clog2(WINDOW_LEN);
  localparam int HSUM_W = HUMID_W + $clog2(WINDOW_LEN);
  localparam int AVG_N  = TSUM_W;
  localparam int AVG_SH = AVG_N + $clog2(WINDOW_LEN);
  localparam int AVG_RW = AVG_N + 1;
  localparam int AVG_PW = AVG_N + AVG_RW;
  localparam logic [AVG_RW-1:0] AVG_RECIP =
    AVG_RW'(((64'd1 << AVG_SH) + WINDOW_LEN - 1) / WINDOW_LEN);

  logic signed [TEMP_F_W-1:0] ring_temp [WINDOW_LEN];
  logic [HUMID_W-1:0]         ring_humid [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]      ring_vld;
  logic [SLOT_W-1:0]          slot;
  logic signed [TEMP_F_W-1:0] rd_temp;
  logic [HUMID_W-1:0]         rd_humid;
  logic                       rd_vld;
  logic signed [TEMP_F_W-1:0] old_temp;
  logic [HUMID_W-1:0]         old_humid;

  logic signed [TSUM_W-1:0]   temp_sum;
  logic signed [TSUM_W-1:0]   temp_sum_neg;
  logic [HSUM_W-1:0]          humid_sum;
  logic [TSUM_W-1:0]          temp_mag;

  logic signed [TEMP9_W-1:0]  c_ext;
  logic signed [TEMP9_W-1:0]  c9;
  logic signed [TEMP9_W-1:0]  c9_neg;
  logic [MAG_W-1:0]           mag;
  logic                       mag_neg;
  logic [PROD_W-1:0]          prod;
  logic [TEMP_F_W-1:0]        fq;
  logic signed [TEMP_F_W-1:0] f_val;
  logic [HUMID_W-1:0]         h_val;
  logic [BATT_W-1:0]          raw_val;
  logic [BATT_W-1:0]          batt_diff;

  logic                       batt_clamp;
  logic [NUM_W-1:0]           batt_num;
  logic [DVSR_W-1:0]          batt_den;

  logic                       div_busy;
  logic [NUM_W-1:0]           div_quo;

  logic [AVG_PW-1:0]          tavg_prod;
  logic [AVG_PW-1:0]          havg_prod;
  logic                       tavg_neg;
  logic [TEMP_F_W-1:0]        tq;
  logic signed [TEMP_F_W-1:0] tavg;
  logic [HUMID_W-1:0]         havg;
  logic [PCT_W-1:0]           bpct;

  assign c_ext     = TEMP9_W'(temp_centi_c);
  assign c9        = (c_ext <<< 3) + c_ext;
  assign c9_neg    = -c9;
  assign fq        = prod[RECIP_SH+TEMP_F_W-1:RECIP_SH];
  assign old_temp  = rd_vld ? rd_temp : '0;
  assign old_humid = rd_vld ? rd_humid : '0;
  assign batt_diff = raw_val - batt_empty_level;
  assign temp_sum_neg = -temp_sum;
  assign temp_mag  = temp_sum[TSUM_W-1] ? temp_sum_neg : temp_sum;
  assign tq        = tavg_prod[AVG_SH +: TEMP_F_W];
  assign tavg      = tavg_neg ? $signed(~tq + 1'b1) : $signed(tq);
  assign havg      = havg_prod[AVG_SH +: HUMID_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_neg  <= c9[TEMP9_W-1];
      mag      <= c9[TEMP9_W-1] ? c9_neg[MAG_W-1:0] : c9[MAG_W-1:0];
      h_val    <= humid_centi_pct;
      raw_val  <= batt_raw;
      rd_temp  <= ring_temp[slot];
      rd_humid <= ring_humid[slot];
      rd_vld   <= ring_vld[slot];
    end
    if (cmd.mul) begin
      prod <= PROD_W'(mag) * PROD_W'(F_RECIP);
    end
    if (cmd.fconv) begin
      f_val <= mag_neg ? (F_OFFSET - $signed(fq)) : (F_OFFSET + $signed(fq));
    end
    if (cmd.upd) begin
      ring_temp[slot]  <= f_val;
      ring_humid[slot] <= h_val;
      batt_num         <= NUM_W'(batt_diff) * NUM_W'(BATT_MAX);
      batt_den         <= batt_full_level - batt_empty_level;
      if (raw_val >= batt_full_level) begin
        batt_clamp <= 1'b1;
        bpct       <= BATT_MAX;
      end else if (raw_val <= batt_empty_level) begin
        batt_clamp <= 1'b1;
        bpct       <= BATT_MIN;
      end else begin
        batt_clamp <= 1'b0;
      end
    end
    if (cmd.avg) begin
      tavg_neg  <= temp_sum[TSUM_W-1];
      tavg_prod <= AVG_PW'(temp_mag) * AVG_PW'(AVG_RECIP);
      havg_prod <= AVG_PW'(humid_sum) * AVG_PW'(AVG_RECIP);
    end
    if (cmd.cap_batt) begin
      bpct <= div_quo[PCT_W-1:0];
    end
    if (cmd.emit) begin
      temp_centi_f     <= f_val;
      humid_now        <= h_val;
      temp_avg_centi_f <= tavg;
      humid_avg        <= havg;
      batt_percent     <= bpct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld     <= '0;
      slot         <= '0;
      temp_sum     <= '0;
      humid_sum    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.upd) begin
        ring_vld[slot] <= 1'b1;
        slot      <= (slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot + 1'b1;
        temp_sum  <= temp_sum + TSUM_W'(f_val) - TSUM_W'(old_temp);
        humid_sum <= humid_sum + HSUM_W'(h_val) - HSUM_W'(old_humid);
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  esabg_div #(
    .DIV_W(NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (batt_num),
    .divisor  (batt_den),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign status = '{div_busy: div_busy, batt_clamp: batt_clamp,
                    out_free: !result_valid || result_ready};

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW_LEN - 1))
    else $error("ring slot beyond window");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_valid || result_ready))
    else $error("result overwritten before it was taken");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> result_valid)
    else $error("result word not presented after emit");

endmodule

`default_nettype wire

// ===== rtl/core/env_sample_averager_batt_gauge.sv =====
// ----------------------------------------------------------------------------
// env_sample_averager_batt_gauge
// Converts each sample word to Fahrenheit, keeps window averages of
// temperature and humidity and estimates battery charge.
// ----------------------------------------------------------------------------
// A sample word taken in the idle state runs through the multiply, Fahrenheit
// conversion, ring update, average and battery start states, then the 17-step
// battery division, and is emitted as a result word; the division is skipped
// when the battery reading clamps. A new sample word is taken only after the
// last result is emitted, and an untaken result holds the next one back.
// Synchronous reset empties the rings at once and loads levels 700 and 560.
`default_nettype none

module env_sample_averager_batt_gauge
  import esabg_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ADDR_W-1:0]          paddr,
  input  wire logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]               prdata,
  output logic                            pready,
  input  wire logic                       sample_valid,
  output logic                            sample_ready,
  input  wire logic signed [TEMP_C_W-1:0] temp_centi_c,
  input  wire logic [HUMID_W-1:0]         humid_centi_pct,
  input  wire logic [BATT_W-1:0]          batt_raw,
  output logic                            result_valid,
  input  wire logic                       result_ready,
  output logic signed [TEMP_F_W-1:0]      temp_centi_f,
  output logic [HUMID_W-1:0]              humid_now,
  output logic signed [TEMP_F_W-1:0]      temp_avg_centi_f,
  output logic [HUMID_W-1:0]              humid_avg,
  output logic [PCT_W-1:0]                batt_percent
);

  logic [BATT_W-1:0] batt_full_level;
  logic [BATT_W-1:0] batt_empty_level;
  logic              wr_en;
  cmd_t              cmd;
  status_t           status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      batt_full_level  <= FULL_RST;
      batt_empty_level <= EMPTY_RST;
    end else if (wr_en) begin
      case (paddr[2:2])
        REG_FULL:  batt_full_level  <= pwdata[BATT_W-1:0];
        REG_EMPTY: batt_empty_level <= pwdata[BATT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2:2])
      REG_FULL:  prdata = DATA_W'(batt_full_level);
      REG_EMPTY: prdata = DATA_W'(batt_empty_level);
      default:   prdata = '0;
    endcase
  end

  esabg_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  esabg_dp #(
    .WINDOW_LEN(WINDOW_LEN)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .temp_centi_c     (temp_centi_c),
    .humid_centi_pct  (humid_centi_pct),
    .batt_raw         (batt_raw),
    .batt_full_level  (batt_full_level),
    .batt_empty_level (batt_empty_level),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .temp_centi_f     (temp_centi_f),
    .humid_now        (humid_now),
    .temp_avg_centi_f (temp_avg_centi_f),
    .humid_avg        (humid_avg),
    .batt_percent     (batt_percent)
  );

endmodule

`default_nettype wire

// ===== tb/tb_env_sample_averager_batt_gauge.sv =====
// ----------------------------------------------------------------------------
// tb_env_sample_averager_batt_gauge
// Self-checking bench for the environment sample averager with battery gauge.
// Sample words go in through a valid/ready channel in bursts with random gaps.
// Result words are taken with a receiver that stalls on its own pattern. Each
// result word is compared field by field with a local model of the Fahrenheit
// conversion, the two window averages and the battery gauge. The level
// registers are written and read back over APB while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_env_sample_averager_batt_gauge;
  import esabg_pkg::*;

  localparam int WIN         = WINDOW_LEN_DEF;
  localparam int DRAIN_WAIT  = 100;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [ADDR_W-1:0] FULL_ADDR  = {REG_FULL, 2'b00};
  localparam logic [ADDR_W-1:0] EMPTY_ADDR = {REG_EMPTY, 2'b00};

  typedef struct {
    logic signed [TEMP_F_W-1:0] temp_f;
    logic [HUMID_W-1:0]         humid;
    logic signed [TEMP_F_W-1:0] temp_avg;
    logic [HUMID_W-1:0]         humid_avg;
    logic [PCT_W-1:0]           pct;
  } gauge_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ADDR_W-1:0]          paddr = '0;
  logic [DATA_W-1:0]          pwdata = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;
  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  logic signed [TEMP_C_W-1:0] temp_centi_c = '0;
  logic [HUMID_W-1:0]         humid_centi_pct = '0;
  logic [BATT_W-1:0]          batt_raw = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic signed [TEMP_F_W-1:0] temp_centi_f;
  logic [HUMID_W-1:0]         humid_now;
  logic signed [TEMP_F_W-1:0] temp_avg_centi_f;
  logic [HUMID_W-1:0]         humid_avg;
  logic [PCT_W-1:0]           batt_percent;

  env_sample_averager_batt_gauge u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .sample_valid     (sample_valid),
    .sample_ready     (sample_ready),
    .temp_centi_c     (temp_centi_c),
    .humid_centi_pct  (humid_centi_pct),
    .batt_raw         (batt_raw),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .temp_centi_f     (temp_centi_f),
    .humid_now        (humid_now),
    .temp_avg_centi_f (temp_avg_centi_f),
    .humid_avg        (humid_avg),
    .batt_percent     (batt_percent)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gauge_result_t     pending_results[$];
  int                error_count = 0;
  int unsigned       cycle_count = 0;
  int                burst_left = 0;

  int                temp_ring[WIN];
  int                humid_ring[WIN];
  int                ring_slot;
  int                temp_sum;
  int                humid_sum;
  logic [BATT_W-1:0] full_lvl;
  logic [BATT_W-1:0] empty_lvl;

  task automatic report_error(input string msg);
    $display("ERROR [%0t] %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int expv);
    if (got != expv) begin
      report_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, expv));
    end
  endtask

  task automatic reset_gauge_model();
    for (int i = 0; i < WIN; i++) begin
      temp_ring[i] = 0;
      humid_ring[i] = 0;
    end
    ring_slot = 0;
    temp_sum = 0;
    humid_sum = 0;
    full_lvl = FULL_RST;
    empty_lvl = EMPTY_RST;
  endtask

  task automatic apply_sample(input logic signed [TEMP_C_W-1:0] c,
                              input logic [HUMID_W-1:0] h,
                              input logic [BATT_W-1:0] raw);
    int            f;
    int            tavg;
    int            havg;
    gauge_result_t r;
    f = (int'(c) * 9) / 5 + 3200;
    temp_sum += f - temp_ring[ring_slot];
    humid_sum += int'(h) - humid_ring[ring_slot];
    temp_ring[ring_slot] = f;
    humid_ring[ring_slot] = int'(h);
    ring_slot = (ring_slot == WIN - 1) ? 0 : ring_slot + 1;
    tavg = temp_sum / WIN;
    havg = humid_sum / WIN;
    r.temp_f = f[TEMP_F_W-1:0];
    r.humid = h;
    r.temp_avg = tavg[TEMP_F_W-1:0];
    r.humid_avg = havg[HUMID_W-1:0];
    if (raw >= full_lvl) begin
      r.pct = BATT_MAX;
    end else if (raw <= empty_lvl) begin
      r.pct = BATT_MIN;
    end else begin
      r.pct = PCT_W'((99 * (int'(raw) - int'(empty_lvl))) /
                     (int'(full_lvl) - int'(empty_lvl)));
    end
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin : result_checker
    gauge_result_t e;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        report_error("result word with no expectation waiting");
      end else begin
        e = pending_results.pop_front();
        check_field("temp_centi_f", int'(temp_centi_f), int'(e.temp_f));
        check_field("humid_now", int'(humid_now), int'(e.humid));
        check_field("temp_avg_centi_f", int'(temp_avg_centi_f), int'(e.temp_avg));
        check_field("humid_avg", int'(humid_avg), int'(e.humid_avg));
        check_field("batt_percent", int'(batt_percent), int'(e.pct));
      end
    end
  end

  int unsigned rx_count = 0;
  int          rx_mode = 0;

  always @(posedge clk) begin
    rx_count <= rx_count + 1;
    if (rx_count[7:0] == 8'd0) begin
      rx_mode <= int'($urandom_range(0, 3));
    end
    case (rx_mode)
      0: begin
        result_ready <= 1'b1;
      end
      1: begin
        result_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        result_ready <= (rx_count[5:0] >= 6'd30);
      end
      default: begin
        result_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  task automatic send_sample(input logic signed [TEMP_C_W-1:0] c,
                             input logic [HUMID_W-1:0] h,
                             input logic [BATT_W-1:0] raw);
    int gap;
    sample_valid <= 1'b1;
    temp_centi_c <= c;
    humid_centi_pct <= h;
    batt_raw <= raw;
    do @(posedge clk); while (!sample_ready);
    apply_sample(c, h, raw);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 5) : $urandom_range(1, 90);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_until_idle();
    if (sample_valid) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [BATT_W-1:0] value);
    logic [DATA_W-1:0] data;
    data = {$urandom()};
    data[BATT_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == FULL_ADDR) begin
      full_lvl = value;
    end else if (addr == EMPTY_ADDR) begin
      empty_lvl = value;
    end
    @(posedge clk);
  endtask

  task automatic apb_check_read(input logic [ADDR_W-1:0] addr, input logic [BATT_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(DATA_W-BATT_W){1'b0}}, value}) begin
      report_error($sformatf("register read at 0x%0h: got 0x%0h, expected 0x%0h",
                             addr, prdata, value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_levels(input logic [BATT_W-1:0] full, input logic [BATT_W-1:0] empty);
    wait_until_idle();
    apb_write(FULL_ADDR, full);
    apb_write(EMPTY_ADDR, empty);
    apb_check_read(FULL_ADDR, full);
    apb_check_read(EMPTY_ADDR, empty);
  endtask

  task automatic send_random_sample();
    logic signed [TEMP_C_W-1:0] c;
    logic [HUMID_W-1:0]         h;
    int                         raw;
    if ($urandom_range(0, 9) == 0) begin
      c = TEMP_C_W'($urandom());
    end else begin
      c = TEMP_C_W'(int'($urandom_range(0, 12500)) - 4000);
    end
    if ($urandom_range(0, 9) == 0) begin
      h = HUMID_W'($urandom());
    end else begin
      h = HUMID_W'($urandom_range(0, 10000));
    end
    if ($urandom_range(0, 9) < 3) begin
      raw = ($urandom_range(0, 1) == 0) ? int'(full_lvl) : int'(empty_lvl);
      raw = raw + int'($urandom_range(0, 4)) - 2;
      if (raw < 0) raw = 0;
      if (raw > 1023) raw = 1023;
    end else begin
      raw = $urandom_range(0, 1023);
    end
    send_sample(c, h, BATT_W'(raw));
  endtask

  task automatic test_reset_values();
    apb_check_read(FULL_ADDR, FULL_RST);
    apb_check_read(EMPTY_ADDR, EMPTY_RST);
  endtask

  task automatic test_directed_samples();
    send_sample(-15'sd4000, 14'd0, 10'd0);
    send_sample(15'sd8500, 14'd10000, 10'd1023);
    send_sample(15'sd0, 14'd1, 10'd560);
    send_sample(-15'sd1, 14'd16383, 10'd561);
    send_sample(15'sd1, 14'd5000, 10'd559);
    send_sample(-15'sd16384, 14'd0, 10'd699);
    send_sample(15'sd16383, 14'd16383, 10'd700);
    send_sample(-15'sd3, 14'd8191, 10'd701);
    send_sample(15'sd3, 14'd8192, 10'd630);
    send_sample(-15'sd5, 14'd10000, 10'd512);
    send_sample(-15'sd1778, 14'd123, 10'd1);
    send_sample(-15'sd1779, 14'd9999, 10'd1022);
    for (int i = 0; i < 10; i++) begin
      send_sample(-15'sd16384, 14'd16383, 10'd600 + 10'(i * 10));
    end
  endtask

  task automatic test_level_extremes();
    set_levels(10'd1023, 10'd0);
    send_sample(15'sd2500, 14'd4000, 10'd0);
    send_sample(15'sd2500, 14'd4000, 10'd1);
    send_sample(15'sd2500, 14'd4000, 10'd512);
    send_sample(15'sd2500, 14'd4000, 10'd1022);
    send_sample(15'sd2500, 14'd4000, 10'd1023);
    set_levels(10'd0, 10'd1023);
    send_sample(-15'sd100, 14'd50, 10'd0);
    send_sample(-15'sd100, 14'd50, 10'd512);
    send_sample(-15'sd100, 14'd50, 10'd1023);
    set_levels(10'd500, 10'd500);
    send_sample(15'sd100, 14'd60, 10'd499);
    send_sample(15'sd100, 14'd60, 10'd500);
    send_sample(15'sd100, 14'd60, 10'd501);
    set_levels(10'd1023, 10'd1022);
    send_sample(15'sd7, 14'd70, 10'd1021);
    send_sample(15'sd7, 14'd70, 10'd1022);
    send_sample(15'sd7, 14'd70, 10'd1023);
  endtask

  task automatic test_random_samples();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        set_levels(FULL_RST, EMPTY_RST);
      end else begin
        set_levels(BATT_W'($urandom_range(0, 1023)), BATT_W'($urandom_range(0, 1023)));
      end
      for (int i = 0; i < 170; i++) begin
        send_random_sample();
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    reset_gauge_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed_samples();
    test_level_extremes();
    test_random_samples();
    wait_until_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
